/* hdl/wes_pkg.sv */
// ============================================================================
// wes_pkg: shared types and constants of the wave equation stencil step
// Field widths, fixed-point scaling, operation codes, sequencer states and
// the control groups passed between the core, frame store and MAC unit.
// ============================================================================
package wes_pkg;

    localparam int WORD_W  = 32;            // Q16.16 height
    localparam int COEF_W  = 24;            // unsigned Q8.16 coefficient
    localparam int COORD_W = 6;             // row / col field width
    localparam int CFG_INDEX_W = 2;
    localparam int FRAC_W  = 16;
    localparam int MULB_W  = COEF_W + 2;    // holds 2 * (coef_x + coef_y)
    localparam int PROD_W  = WORD_W + MULB_W + 1;
    localparam int ACC_W   = 61;            // exact Q.32 sum stays below 2^59
    localparam int Q_W     = ACC_W - FRAC_W;

    localparam logic [CFG_INDEX_W-1:0] CFG_COEF_X = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COEF_Y = 2'd1;

    localparam logic [COEF_W-1:0] COEF_RESET = 24'd65536;
    localparam logic [MULB_W-1:0] SCALE_TWO_U = 26'd131072;  // 2u in Q.32
    localparam logic [MULB_W-1:0] SCALE_PRIOR = 26'd65536;   // p in Q.32
    localparam logic signed [ACC_W-1:0] ROUND_HALF = 61'sd32768;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fffffff;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh80000000;

    typedef enum logic [1:0] {
        OP_LOAD_CUR = 2'd0,
        OP_LOAD_PRI = 2'd1,
        OP_COMPUTE  = 2'd2
    } wes_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_READ_0,
        ST_READ_1,
        ST_READ_2,
        ST_READ_3,
        ST_MAC,
        ST_DRAIN,
        ST_FINISH
    } wes_state_t;

    // Terms of the stencil sum, in the order the MAC consumes them
    typedef enum logic [2:0] {
        TERM_U2,
        TERM_P,
        TERM_LEFT,
        TERM_RIGHT,
        TERM_UP,
        TERM_DOWN,
        TERM_CENTER
    } wes_term_t;

    typedef struct packed {
        logic init;     // preload accumulator with the rounding half
        logic mul;      // capture a new product
        logic sub;      // product is subtracted
    } wes_mac_ctl_t;

    typedef struct packed {
        logic cur_we;
        logic pri_we;
    } wes_mem_ctl_t;

endpackage

/* hdl/wave_equation_stencil_step_core.sv */
// ============================================================================
// wave_equation_stencil_step_core: one point of a 2D wave equation step
// Loads points into the current or prior frame and computes the next-step
// height of a point on a torus grid in saturating Q16.16.
// ============================================================================
// A load item holds item_stall for one cycle after its accept beat and is
// written on that cycle, so the next item is taken only after the write. A
// compute item holds item_stall while the sequencer steps through four
// frame read states on the two read ports of the current frame, then seven
// passes through the single 32 x 26 bit multiply-accumulate unit, a drain
// state and a finish state that rounds, saturates and loads the result
// register; it stays in the finish state while a previous result beat is
// still stalled. An unused operation code is dropped in its accept cycle.
// Coordinates are reduced modulo GRID_SIDE, and neighbors wrap at the grid
// edges. Frames are not cleared at reset: read only points that have been
// loaded. Coefficient writes are taken on any cycle.
module wave_equation_stencil_step_core #(
    parameter int GRID_SIDE = 64
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      item_valid,
    output logic                                      item_stall,
    input  logic [1:0]                                operation,
    input  logic [wes_pkg::COORD_W-1:0]               row,
    input  logic [wes_pkg::COORD_W-1:0]               col,
    input  logic signed [wes_pkg::WORD_W-1:0]         load_value,
    output logic                                      result_valid,
    input  logic                                      result_stall,
    output logic signed [wes_pkg::WORD_W-1:0]         next_value,
    output logic                                      saturated,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [wes_pkg::CFG_INDEX_W-1:0]           cfg_index,
    input  logic [wes_pkg::COEF_W-1:0]                cfg_data
);

    localparam int CW    = $clog2(GRID_SIDE);
    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int LUT_N = 2 ** wes_pkg::COORD_W;

    // ------------------------------------------------------------------
    // Coordinate reduction table
    // ------------------------------------------------------------------
    logic [CW-1:0] mod_lut [LUT_N];

    for (genvar gi = 0; gi < LUT_N; gi++)
    begin : g_mod_lut
        assign mod_lut[gi] = CW'(gi % GRID_SIDE);
    end

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r,
                                                input logic [CW-1:0] c);
        return AW'(r) * AW'(GRID_SIDE) + AW'(c);
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [wes_pkg::COEF_W-1:0] coef_x_reg;
    logic [wes_pkg::COEF_W-1:0] coef_y_reg;
    logic [wes_pkg::MULB_W-1:0] coef_sum2;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_x_reg <= wes_pkg::COEF_RESET;
            coef_y_reg <= wes_pkg::COEF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == wes_pkg::CFG_COEF_X)
            begin
                coef_x_reg <= cfg_data;
            end
            else if (cfg_index == wes_pkg::CFG_COEF_Y)
            begin
                coef_y_reg <= cfg_data;
            end
        end
    end

    assign coef_sum2 = wes_pkg::MULB_W'({1'b0, coef_x_reg} + {1'b0, coef_y_reg}) << 1;

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    wes_pkg::wes_state_t   state_reg;
    wes_pkg::wes_state_t   state_next;
    wes_pkg::wes_term_t    step_reg;
    wes_pkg::wes_term_t    step_next;
    wes_pkg::wes_mac_ctl_t mac_ctl;
    wes_pkg::wes_mem_ctl_t mem_ctl;
    logic                  out_load;
    logic                  item_accept;

    logic [CW-1:0]                    row_reg;
    logic [CW-1:0]                    col_reg;
    logic signed [wes_pkg::WORD_W-1:0] val_reg;
    logic                             load_pri_reg;

    logic signed [wes_pkg::WORD_W-1:0] u_reg;
    logic signed [wes_pkg::WORD_W-1:0] p_reg;
    logic signed [wes_pkg::WORD_W-1:0] left_reg;
    logic signed [wes_pkg::WORD_W-1:0] right_reg;
    logic signed [wes_pkg::WORD_W-1:0] up_reg;
    logic signed [wes_pkg::WORD_W-1:0] down_reg;

    logic                              result_valid_reg;
    logic                              result_valid_next;
    logic signed [wes_pkg::WORD_W-1:0] next_value_reg;
    logic                              saturated_reg;

    assign item_stall  = (state_reg != wes_pkg::ST_IDLE);
    assign item_accept = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= wes_pkg::ST_IDLE;
            step_reg         <= wes_pkg::TERM_U2;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        mac_ctl    = '0;
        mem_ctl    = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            wes_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (wes_pkg::wes_op_t'(operation))
                        wes_pkg::OP_LOAD_CUR,
                        wes_pkg::OP_LOAD_PRI: state_next = wes_pkg::ST_LOAD;
                        wes_pkg::OP_COMPUTE:  state_next = wes_pkg::ST_READ_0;
                        default:              state_next = wes_pkg::ST_IDLE;
                    endcase
                end
            end
            wes_pkg::ST_LOAD:
            begin
                mem_ctl.cur_we = !load_pri_reg;
                mem_ctl.pri_we = load_pri_reg;
                state_next     = wes_pkg::ST_IDLE;
            end
            wes_pkg::ST_READ_0:
            begin
                mac_ctl.init = 1'b1;
                state_next   = wes_pkg::ST_READ_1;
            end
            wes_pkg::ST_READ_1:
            begin
                state_next = wes_pkg::ST_READ_2;
            end
            wes_pkg::ST_READ_2:
            begin
                state_next = wes_pkg::ST_READ_3;
            end
            wes_pkg::ST_READ_3:
            begin
                step_next  = wes_pkg::TERM_U2;
                state_next = wes_pkg::ST_MAC;
            end
            wes_pkg::ST_MAC:
            begin
                mac_ctl.mul = 1'b1;
                mac_ctl.sub = (step_reg == wes_pkg::TERM_P) ||
                              (step_reg == wes_pkg::TERM_CENTER);
                if (step_reg == wes_pkg::TERM_CENTER)
                begin
                    state_next = wes_pkg::ST_DRAIN;
                end
                else
                begin
                    step_next = wes_pkg::wes_term_t'(step_reg + 3'd1);
                end
            end
            wes_pkg::ST_DRAIN:
            begin
                state_next = wes_pkg::ST_FINISH;
            end
            wes_pkg::ST_FINISH:
            begin
                // hold until the result register is free or being emptied
                if (!result_valid_reg || !result_stall)
                begin
                    out_load   = 1'b1;
                    state_next = wes_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wes_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            row_reg      <= mod_lut[row];
            col_reg      <= mod_lut[col];
            val_reg      <= load_value;
            load_pri_reg <= (operation == wes_pkg::OP_LOAD_PRI);
        end
    end

    // ------------------------------------------------------------------
    // Neighbor addresses and frame store
    // ------------------------------------------------------------------
    logic [CW-1:0] row_m;
    logic [CW-1:0] row_p;
    logic [CW-1:0] col_m;
    logic [CW-1:0] col_p;
    logic [CW-1:0] a_row;
    logic [CW-1:0] a_col;
    logic [CW-1:0] b_row;
    logic [CW-1:0] b_col;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    logic [AW-1:0] wr_addr;
    logic [wes_pkg::WORD_W-1:0] rd_data_a;
    logic [wes_pkg::WORD_W-1:0] rd_data_b;
    logic [wes_pkg::WORD_W-1:0] rd_data_p;

    assign row_m = (row_reg == '0) ? CW'(GRID_SIDE - 1) : row_reg - CW'(1);
    assign row_p = (row_reg == CW'(GRID_SIDE - 1)) ? '0 : row_reg + CW'(1);
    assign col_m = (col_reg == '0) ? CW'(GRID_SIDE - 1) : col_reg - CW'(1);
    assign col_p = (col_reg == CW'(GRID_SIDE - 1)) ? '0 : col_reg + CW'(1);

    // port A: center, right, down; port B: left, up
    always_comb
    begin
        a_row = row_reg;
        a_col = col_reg;
        b_row = row_reg;
        b_col = col_m;
        if (state_reg == wes_pkg::ST_READ_1)
        begin
            a_col = col_p;
            b_row = row_m;
            b_col = col_reg;
        end
        else if (state_reg == wes_pkg::ST_READ_2)
        begin
            a_row = row_p;
        end
    end

    assign rd_addr_a = cell_addr(a_row, a_col);
    assign rd_addr_b = cell_addr(b_row, b_col);
    assign wr_addr   = cell_addr(row_reg, col_reg);

    wes_frames #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_frames (
        .clk       (clk),
        .ctl       (mem_ctl),
        .wr_addr   (wr_addr),
        .wr_data   (val_reg),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b),
        .rd_data_p (rd_data_p)
    );

    // capture read data in the state after each address state, from the registered read ports
    always_ff @(posedge clk)
    begin
        if (state_reg == wes_pkg::ST_READ_1)
        begin
            u_reg    <= rd_data_a;
            left_reg <= rd_data_b;
            p_reg    <= rd_data_p;
        end
        else if (state_reg == wes_pkg::ST_READ_2)
        begin
            right_reg <= rd_data_a;
            up_reg    <= rd_data_b;
        end
        else if (state_reg == wes_pkg::ST_READ_3)
        begin
            down_reg <= rd_data_a;
        end
    end

    // ------------------------------------------------------------------
    // Shared MAC and operand select
    // ------------------------------------------------------------------
    logic signed [wes_pkg::WORD_W-1:0] mac_a;
    logic [wes_pkg::MULB_W-1:0]        mac_b;
    logic signed [wes_pkg::ACC_W-1:0]  acc;

    always_comb
    begin
        unique case (step_reg)
            wes_pkg::TERM_U2:
            begin
                mac_a = u_reg;
                mac_b = wes_pkg::SCALE_TWO_U;
            end
            wes_pkg::TERM_P:
            begin
                mac_a = p_reg;
                mac_b = wes_pkg::SCALE_PRIOR;
            end
            wes_pkg::TERM_LEFT:
            begin
                mac_a = left_reg;
                mac_b = wes_pkg::MULB_W'(coef_x_reg);
            end
            wes_pkg::TERM_RIGHT:
            begin
                mac_a = right_reg;
                mac_b = wes_pkg::MULB_W'(coef_x_reg);
            end
            wes_pkg::TERM_UP:
            begin
                mac_a = up_reg;
                mac_b = wes_pkg::MULB_W'(coef_y_reg);
            end
            wes_pkg::TERM_DOWN:
            begin
                mac_a = down_reg;
                mac_b = wes_pkg::MULB_W'(coef_y_reg);
            end
            wes_pkg::TERM_CENTER:
            begin
                mac_a = u_reg;
                mac_b = coef_sum2;
            end
            default:
            begin
                mac_a = u_reg;
                mac_b = '0;
            end
        endcase
    end

    wes_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .opa   (mac_a),
        .opb   (mac_b),
        .acc   (acc)
    );

    // ------------------------------------------------------------------
    // Round (floor after the preloaded half), saturate, result register
    // ------------------------------------------------------------------
    logic signed [wes_pkg::Q_W-1:0]             q;
    logic [wes_pkg::Q_W-wes_pkg::WORD_W:0]      q_high;
    logic                                       q_fits;
    logic signed [wes_pkg::WORD_W-1:0]          sat_value;

    assign q         = acc[wes_pkg::ACC_W-1:wes_pkg::FRAC_W];
    assign q_high    = q[wes_pkg::Q_W-1:wes_pkg::WORD_W-1];
    assign q_fits    = (q_high == '0) || (q_high == '1);
    assign sat_value = q_fits ? q[wes_pkg::WORD_W-1:0]
                     : (q[wes_pkg::Q_W-1] ? wes_pkg::WORD_MIN : wes_pkg::WORD_MAX);

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            next_value_reg <= sat_value;
            saturated_reg  <= !q_fits;
        end
    end

    assign result_valid = result_valid_reg;
    assign next_value   = next_value_reg;
    assign saturated    = saturated_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_compute_starts_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (item_accept && operation == wes_pkg::OP_COMPUTE) |=>
            (state_reg == wes_pkg::ST_READ_0))
        else $error("compute beat did not start the frame reads");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == wes_pkg::ST_FINISH))
        else $error("result beat raised outside the finish step");

    a_saturated_is_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && saturated) |->
            (next_value == wes_pkg::WORD_MAX || next_value == wes_pkg::WORD_MIN))
        else $error("saturated result is not a range limit");

    a_mac_only_in_mac: assert property (@(posedge clk) disable iff (!rst_n)
        mac_ctl.mul |-> (state_reg == wes_pkg::ST_MAC && !item_accept))
        else $error("multiply issued outside the MAC sequence");

endmodule

/* hdl/wes_frames.sv */
// ============================================================================
// wes_frames: current and prior frame store
// Current frame has one write port and two registered read ports; prior
// frame has one write port and one registered read port.
// ============================================================================
module wes_frames #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                              clk,
    input  wes_pkg::wes_mem_ctl_t             ctl,
    input  logic [AW-1:0]                     wr_addr,
    input  logic [wes_pkg::WORD_W-1:0]        wr_data,
    input  logic [AW-1:0]                     rd_addr_a,
    input  logic [AW-1:0]                     rd_addr_b,
    output logic [wes_pkg::WORD_W-1:0]        rd_data_a,
    output logic [wes_pkg::WORD_W-1:0]        rd_data_b,
    output logic [wes_pkg::WORD_W-1:0]        rd_data_p
);

    logic [wes_pkg::WORD_W-1:0] cur_mem [DEPTH];
    logic [wes_pkg::WORD_W-1:0] pri_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.cur_we)
        begin
            cur_mem[wr_addr] <= wr_data;
        end
        rd_data_a <= cur_mem[rd_addr_a];
        rd_data_b <= cur_mem[rd_addr_b];
    end

    // prior value is always wanted at the center point, port A's address
    always_ff @(posedge clk)
    begin
        if (ctl.pri_we)
        begin
            pri_mem[wr_addr] <= wr_data;
        end
        rd_data_p <= pri_mem[rd_addr_a];
    end

endmodule

/* hdl/wes_mac.sv */
// ============================================================================
// wes_mac: shared multiply-accumulate unit
// One signed word times one unsigned scale per cycle into a product
// register; the product is added to or subtracted from the accumulator on
// the following cycle.
// ============================================================================
module wes_mac (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  wes_pkg::wes_mac_ctl_t                ctl,
    input  logic signed [wes_pkg::WORD_W-1:0]    opa,
    input  logic [wes_pkg::MULB_W-1:0]           opb,
    output logic signed [wes_pkg::ACC_W-1:0]     acc
);

    logic signed [wes_pkg::PROD_W-1:0] prod_reg;
    logic signed [wes_pkg::PROD_W-1:0] prod_next;
    logic                              sub_reg;
    logic                              prod_valid_reg;
    logic signed [wes_pkg::ACC_W-1:0]  acc_reg;
    logic signed [wes_pkg::ACC_W-1:0]  acc_next;
    logic signed [wes_pkg::ACC_W-1:0]  prod_ext;

    assign prod_next = opa * $signed({1'b0, opb});
    assign prod_ext  = wes_pkg::ACC_W'(prod_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.init)
        begin
            acc_next = wes_pkg::ROUND_HALF;
        end
        else if (prod_valid_reg)
        begin
            acc_next = sub_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctl.mul;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul)
        begin
            prod_reg <= prod_next;
            sub_reg  <= ctl.sub;
        end
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule
